// ----- hw/rtl/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared constants, header layout and status codes.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_BYTES   = 16384;
    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 4;

    localparam int ADDR_W  = $clog2(HEAP_BYTES);
    localparam int SIZE_W  = 15;
    localparam int POS_W   = 16;
    localparam int HDR_W   = SIZE_W + 1;
    localparam int PAGE_SH = $clog2(PAGE_BYTES);

    localparam logic [SIZE_W-1:0] USED_MAX = '1;

    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
    } hdr_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NULL    = 2'd1,
        ST_NO_HEAP = 2'd2,
        ST_CORRUPT = 2'd3
    } status_t;

    typedef enum logic {
        CFG_MIN_CHUNK   = 1'b0,
        CFG_LIMIT_PAGES = 1'b1
    } cfg_idx_t;

endpackage

// ----- hw/rtl/first_fit_heap_allocator_top.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Walks chunk headers held in a RAM, grows, splits and merges chunks.
// ----------------------------------------------------------------------------
// An allocation walks the chunk headers and grows the heap at its top chunk; a
// free merges the free chunks that follow; a null or rejected request gives its
// result in the cycle after it is accepted.
// One request at a time; busy is high from the cycle after acceptance until
// the result strobe, and a null or rejected request leaves it low.
// The header RAM read is registered: each header is read in one state, then checked.
// After reset a clearing pass sweeps all of the RAM with busy high.
// The result is shown for one cycle on done; the receiver cannot stall.
module first_fit_heap_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [14:0] req_size,
    input  logic [13:0] free_addr,
    output logic        done,
    output logic [13:0] data_addr,
    output logic [1:0]  status,
    output logic [14:0] used_bytes,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_A_SPLIT,
        S_F_RD,
        S_F_CHK,
        S_M_RD,
        S_M_CHK
    } state_t;

    state_t                          state_reg;
    logic [ffha_pkg::ADDR_W-1:0]     clr_reg;
    logic [ffha_pkg::POS_W-1:0]      pos_reg;
    logic [ffha_pkg::POS_W-1:0]      need_reg;
    logic [ffha_pkg::SIZE_W-1:0]     cur_reg;
    logic [ffha_pkg::SIZE_W-1:0]     top_reg;
    logic [ffha_pkg::SIZE_W-1:0]     used_reg;
    logic [12:0]                     min_reg;
    logic [2:0]                      lim_reg;
    logic                            done_reg;
    logic [13:0]                     addr_reg;
    ffha_pkg::status_t               status_reg;

    logic                            we;
    logic [ffha_pkg::ADDR_W-1:0]     waddr;
    ffha_pkg::hdr_t                  wdata;
    logic [ffha_pkg::ADDR_W-1:0]     raddr;
    ffha_pkg::hdr_t                  rhdr;
    logic [ffha_pkg::HDR_W-1:0]      rdata;

    logic [12:0]                     eff_min;
    logic [ffha_pkg::POS_W-1:0]      lim_bytes;
    logic [ffha_pkg::POS_W-1:0]      chunk_end;
    logic [ffha_pkg::POS_W-1:0]      req_need;
    logic [ffha_pkg::SIZE_W-1:0]     rest;
    logic [ffha_pkg::POS_W-1:0]      grow;
    logic [ffha_pkg::POS_W-1:0]      top_grown;
    logic [ffha_pkg::POS_W-1:0]      used_sum;
    logic [ffha_pkg::POS_W-1:0]      merge_nxt;
    logic [ffha_pkg::POS_W-1:0]      cur_sum;
    logic [ffha_pkg::POS_W-1:0]      free_pos;

    assign rhdr    = ffha_pkg::hdr_t'(rdata);
    assign eff_min = (min_reg == 13'd0) ? 13'd1 : min_reg;
    assign lim_bytes = ({1'b0, lim_reg, 12'd0} > 16'(ffha_pkg::HEAP_BYTES))
        ? 16'(ffha_pkg::HEAP_BYTES) : {1'b0, lim_reg, 12'd0};
    assign req_need = 16'(ffha_pkg::HEADER_BYTES) + {1'b0, req_size};
    assign chunk_end = pos_reg + {1'b0, rhdr.size};
    assign rest = rhdr.size - need_reg[ffha_pkg::SIZE_W-1:0];
    assign grow = 16'(((need_reg >> ffha_pkg::PAGE_SH) + 16'd1)
        << ffha_pkg::PAGE_SH);
    assign top_grown = {1'b0, top_reg} + grow;
    assign used_sum = {1'b0, used_reg} + need_reg;
    assign merge_nxt = pos_reg + {1'b0, cur_reg};
    assign cur_sum = {1'b0, cur_reg} + {1'b0, rhdr.size};
    assign free_pos = {2'b00, free_addr} - 16'(ffha_pkg::HEADER_BYTES);

    ffha_ram #(
        .WIDTH(ffha_pkg::HDR_W),
        .DEPTH(ffha_pkg::HEAP_BYTES)
    ) u_hdr_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        we    = 1'b0;
        waddr = pos_reg[ffha_pkg::ADDR_W-1:0];
        wdata = '0;
        raddr = pos_reg[ffha_pkg::ADDR_W-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata.size = (clr_reg == '0) ? 15'(ffha_pkg::PAGE_BYTES) : '0;
            end
            S_A_CHK:
            begin
                if (rhdr.size != '0 && chunk_end <= {1'b0, top_reg})
                begin
                    if (!rhdr.used && {1'b0, rhdr.size} >= need_reg)
                    begin
                        we = 1'b1;
                        if (rest >= {2'b00, eff_min})
                        begin
                            waddr = ffha_pkg::ADDR_W'(pos_reg + need_reg);
                            wdata.size = rest;
                        end
                        else
                        begin
                            wdata.used = 1'b1;
                            wdata.size = rhdr.size;
                        end
                    end
                    else if (chunk_end == {1'b0, top_reg} && top_grown <= lim_bytes)
                    begin
                        we    = 1'b1;
                        waddr = top_reg[ffha_pkg::ADDR_W-1:0];
                        wdata.size = grow[ffha_pkg::SIZE_W-1:0];
                    end
                end
            end
            S_A_SPLIT:
            begin
                we = 1'b1;
                wdata.used = 1'b1;
                wdata.size = need_reg[ffha_pkg::SIZE_W-1:0];
            end
            S_F_CHK:
            begin
                we = rhdr.used;
                wdata.size = rhdr.size;
            end
            S_M_RD:
            begin
                raddr = merge_nxt[ffha_pkg::ADDR_W-1:0];
            end
            S_M_CHK:
            begin
                we = !rhdr.used && rhdr.size != '0;
                wdata.size = cur_sum[ffha_pkg::SIZE_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            pos_reg    <= '0;
            need_reg   <= '0;
            cur_reg    <= '0;
            top_reg    <= 15'(ffha_pkg::PAGE_BYTES);
            used_reg   <= '0;
            min_reg    <= 13'd16;
            lim_reg    <= 3'd4;
            done_reg   <= 1'b0;
            addr_reg   <= '0;
            status_reg <= ffha_pkg::ST_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (ffha_pkg::cfg_idx_t'(cfg_index))
                    ffha_pkg::CFG_MIN_CHUNK:   min_reg <= cfg_data;
                    ffha_pkg::CFG_LIMIT_PAGES: lim_reg <= cfg_data[2:0];
                endcase
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + ffha_pkg::ADDR_W'(1);
                    if (clr_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        addr_reg <= '0;
                        if (!mode)
                        begin
                            pos_reg  <= '0;
                            need_reg <= (req_need < {3'b000, eff_min})
                                ? {3'b000, eff_min} : req_need;
                            if (req_size == '0)
                            begin
                                status_reg <= ffha_pkg::ST_NULL;
                                done_reg   <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_A_RD;
                            end
                        end
                        else
                        begin
                            pos_reg <= free_pos;
                            priority if (free_addr == '0)
                            begin
                                status_reg <= ffha_pkg::ST_NULL;
                                done_reg   <= 1'b1;
                            end
                            else if (free_addr < 14'(ffha_pkg::HEADER_BYTES)
                                     || free_pos >= {1'b0, top_reg})
                            begin
                                status_reg <= ffha_pkg::ST_CORRUPT;
                                done_reg   <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_F_RD;
                            end
                        end
                    end
                end
                S_A_RD:
                begin
                    if (pos_reg >= {1'b0, top_reg})
                    begin
                        status_reg <= ffha_pkg::ST_CORRUPT;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_A_CHK;
                    end
                end
                S_A_CHK:
                begin
                    priority if (rhdr.size == '0 || chunk_end > {1'b0, top_reg})
                    begin
                        status_reg <= ffha_pkg::ST_CORRUPT;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else if (!rhdr.used && {1'b0, rhdr.size} >= need_reg)
                    begin
                        used_reg   <= (used_sum > {1'b0, ffha_pkg::USED_MAX})
                            ? ffha_pkg::USED_MAX : used_sum[ffha_pkg::SIZE_W-1:0];
                        addr_reg   <= 14'(pos_reg + 16'(ffha_pkg::HEADER_BYTES));
                        status_reg <= ffha_pkg::ST_OK;
                        if (rest >= {2'b00, eff_min})
                        begin
                            state_reg <= S_A_SPLIT;
                        end
                        else
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (chunk_end == {1'b0, top_reg})
                    begin
                        if (top_grown > lim_bytes)
                        begin
                            status_reg <= ffha_pkg::ST_NO_HEAP;
                            done_reg   <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            top_reg   <= top_grown[ffha_pkg::SIZE_W-1:0];
                            pos_reg   <= chunk_end;
                            state_reg <= S_A_RD;
                        end
                    end
                    else
                    begin
                        pos_reg   <= chunk_end;
                        state_reg <= S_A_RD;
                    end
                end
                S_A_SPLIT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_F_RD:
                begin
                    state_reg <= S_F_CHK;
                end
                S_F_CHK:
                begin
                    if (!rhdr.used)
                    begin
                        status_reg <= ffha_pkg::ST_CORRUPT;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        used_reg   <= (used_reg > rhdr.size) ? used_reg - rhdr.size : '0;
                        cur_reg    <= rhdr.size;
                        status_reg <= ffha_pkg::ST_OK;
                        state_reg  <= S_M_RD;
                    end
                end
                S_M_RD:
                begin
                    if (merge_nxt >= {1'b0, top_reg})
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_M_CHK;
                    end
                end
                S_M_CHK:
                begin
                    if (rhdr.used || rhdr.size == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        cur_reg   <= cur_sum[ffha_pkg::SIZE_W-1:0];
                        state_reg <= S_M_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign data_addr  = addr_reg;
    assign status     = status_reg;
    assign used_bytes = used_reg;

endmodule

// ----- hw/rtl/ffha_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
